// File: sv/cpsat_pkg.sv
// Shared constants, types and sequencer codes for the polygon overlap core.
`timescale 1ns / 1ps

package cpsat_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int AXIS_W       = COORD_BITS + 1;
    localparam int PROD_W       = COORD_BITS + AXIS_W;
    localparam int DOT_W        = PROD_W + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [AXIS_W-1:0]     axis_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    // read operation tag, carried down the datapath pipeline
    typedef logic [1:0] op_t;
    localparam op_t OP_NONE  = 2'd0;
    localparam op_t OP_EDGE0 = 2'd1;
    localparam op_t OP_EDGE1 = 2'd2;
    localparam op_t OP_PROJ  = 2'd3;

    typedef struct packed {
        logic load;       // store the incoming vertex
        logic load_sel;   // polygon of the incoming vertex
        logic clear;      // end of pair: counts and drop flag back to zero
        op_t  rd_op;
        logic rd_poly;
        idx_t rd_addr;
        logic rd_first;   // first vertex of a projection run
    } cmd_t;

    typedef struct packed {
        cnt_t count0;
        cnt_t count1;
        logic box_hit;
        logic separated;
        logic dropped;
    } stat_t;

endpackage

// File: sv/cpsat_datapath.sv
// Vertex stores, bounding boxes and the projection pipeline.
`timescale 1ns / 1ps

module cpsat_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cpsat_pkg::cmd_t      cmd,
    input  cpsat_pkg::coord_t    load_x,
    input  cpsat_pkg::coord_t    load_y,
    output cpsat_pkg::stat_t     stat
);

    typedef struct packed {
        cpsat_pkg::op_t op;
        logic           poly;
        logic           first;
    } tag_t;

    cpsat_pkg::vertex_t first_store  [cpsat_pkg::MAX_VERTICES];
    cpsat_pkg::vertex_t second_store [cpsat_pkg::MAX_VERTICES];
    cpsat_pkg::vertex_t rd0_reg, rd1_reg;

    cpsat_pkg::cnt_t count0_reg, count1_reg;
    logic            dropped_reg;

    cpsat_pkg::coord_t l0_reg, r0_reg, t0_reg, b0_reg;
    cpsat_pkg::coord_t l1_reg, r1_reg, t1_reg, b1_reg;

    tag_t tag1_reg, tag2_reg;
    cpsat_pkg::vertex_t p0_reg;
    cpsat_pkg::axis_t   ax_reg, ay_reg;
    cpsat_pkg::prod_t   px_reg, py_reg;
    cpsat_pkg::dot_t    lo0_reg, hi0_reg, lo1_reg, hi1_reg;

    cpsat_pkg::vertex_t load_v;
    cpsat_pkg::vertex_t rd_v;
    cpsat_pkg::dot_t    dot;
    logic               full0, full1;
    logic               wr0, wr1;

    assign load_v = '{x: load_x, y: load_y};
    assign full0  = (count0_reg == cpsat_pkg::CNT_W'(cpsat_pkg::MAX_VERTICES));
    assign full1  = (count1_reg == cpsat_pkg::CNT_W'(cpsat_pkg::MAX_VERTICES));
    assign wr0    = cmd.load && !cmd.load_sel && !full0;
    assign wr1    = cmd.load && cmd.load_sel && !full1;

    // stores: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (wr0) begin
            first_store[count0_reg[cpsat_pkg::IDX_W-1:0]] <= load_v;
        end
        if (wr1) begin
            second_store[count1_reg[cpsat_pkg::IDX_W-1:0]] <= load_v;
        end
        rd0_reg <= first_store[cmd.rd_addr];
        rd1_reg <= second_store[cmd.rd_addr];
    end

    // fill counts and drop flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count0_reg  <= '0;
            count1_reg  <= '0;
            dropped_reg <= 1'b0;
        end else if (cmd.clear) begin
            count0_reg  <= '0;
            count1_reg  <= '0;
            dropped_reg <= 1'b0;
        end else if (cmd.load) begin
            if (wr0) begin
                count0_reg <= count0_reg + 1'b1;
            end
            if (wr1) begin
                count1_reg <= count1_reg + 1'b1;
            end
            if ((!cmd.load_sel && full0) || (cmd.load_sel && full1)) begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // running bounding boxes, built while loading
    always_ff @(posedge aclk) begin
        if (wr0) begin
            if (count0_reg == '0 || load_x < l0_reg) l0_reg <= load_x;
            if (count0_reg == '0 || load_x > r0_reg) r0_reg <= load_x;
            if (count0_reg == '0 || load_y < t0_reg) t0_reg <= load_y;
            if (count0_reg == '0 || load_y > b0_reg) b0_reg <= load_y;
        end
        if (wr1) begin
            if (count1_reg == '0 || load_x < l1_reg) l1_reg <= load_x;
            if (count1_reg == '0 || load_x > r1_reg) r1_reg <= load_x;
            if (count1_reg == '0 || load_y < t1_reg) t1_reg <= load_y;
            if (count1_reg == '0 || load_y > b1_reg) b1_reg <= load_y;
        end
    end

    // pipeline tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '{op: cpsat_pkg::OP_NONE, poly: 1'b0, first: 1'b0};
            tag2_reg <= '{op: cpsat_pkg::OP_NONE, poly: 1'b0, first: 1'b0};
        end else begin
            tag1_reg <= '{op: cmd.rd_op, poly: cmd.rd_poly, first: cmd.rd_first};
            tag2_reg <= tag1_reg;
        end
    end

    assign rd_v = tag1_reg.poly ? rd1_reg : rd0_reg;

    // edge start latch, axis and products
    always_ff @(posedge aclk) begin
        case (tag1_reg.op)
            cpsat_pkg::OP_EDGE0: begin
                p0_reg <= rd_v;
            end
            cpsat_pkg::OP_EDGE1: begin
                ax_reg <= cpsat_pkg::AXIS_W'(p0_reg.y) - cpsat_pkg::AXIS_W'(rd_v.y);
                ay_reg <= cpsat_pkg::AXIS_W'(rd_v.x) - cpsat_pkg::AXIS_W'(p0_reg.x);
            end
            cpsat_pkg::OP_PROJ: begin
                px_reg <= cpsat_pkg::PROD_W'(rd_v.x) * cpsat_pkg::PROD_W'(ax_reg);
                py_reg <= cpsat_pkg::PROD_W'(rd_v.y) * cpsat_pkg::PROD_W'(ay_reg);
            end
            default: begin
            end
        endcase
    end

    assign dot = cpsat_pkg::DOT_W'(px_reg) + cpsat_pkg::DOT_W'(py_reg);

    // projection intervals
    always_ff @(posedge aclk) begin
        if (tag2_reg.op == cpsat_pkg::OP_PROJ) begin
            if (!tag2_reg.poly) begin
                if (tag2_reg.first || dot < lo0_reg) lo0_reg <= dot;
                if (tag2_reg.first || dot > hi0_reg) hi0_reg <= dot;
            end else begin
                if (tag2_reg.first || dot < lo1_reg) lo1_reg <= dot;
                if (tag2_reg.first || dot > hi1_reg) hi1_reg <= dot;
            end
        end
    end

    assign stat.count0    = count0_reg;
    assign stat.count1    = count1_reg;
    assign stat.dropped   = dropped_reg;
    assign stat.box_hit   = (l0_reg < r1_reg) && (r0_reg > l1_reg) &&
                            (t0_reg < b1_reg) && (b0_reg > t1_reg);
    assign stat.separated = (lo0_reg > hi1_reg) || (hi0_reg < lo1_reg);

endmodule

// File: sv/cpsat_ctrl.sv
// Sequencer for loading, axis walk and result hand-off.
`timescale 1ns / 1ps

module cpsat_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_polygon_select,
    input  logic              s_last_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_collide,
    output logic              m_overflow,
    output cpsat_pkg::cmd_t   cmd,
    input  cpsat_pkg::stat_t  stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_EDGE0  = 3'd2;
    localparam logic [2:0] ST_EDGE1  = 3'd3;
    localparam logic [2:0] ST_PROJ   = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_CHECK  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic            side_reg, side_next;
    cpsat_pkg::idx_t edge_reg, edge_next;
    logic            pj_reg, pj_next;
    cpsat_pkg::idx_t j_reg, j_next;
    logic [1:0]      wait_reg, wait_next;
    logic            res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_collide_reg, m_overflow_reg;

    cpsat_pkg::cnt_t n_side, n_pj;
    logic            edge_last, j_last, out_free, accept;

    assign n_side    = side_reg ? stat.count1 : stat.count0;
    assign n_pj      = pj_reg ? stat.count1 : stat.count0;
    assign edge_last = ({1'b0, edge_reg} + 1'b1) == n_side;
    assign j_last    = ({1'b0, j_reg} + 1'b1) == n_pj;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        side_next    = side_reg;
        edge_next    = edge_reg;
        pj_next      = pj_reg;
        j_next       = j_reg;
        wait_next    = wait_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;

        cmd          = '0;
        cmd.rd_op    = cpsat_pkg::OP_NONE;
        cmd.load     = accept;
        cmd.load_sel = s_polygon_select;

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_last_item) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.count0 == '0 || stat.count1 == '0 || !stat.box_hit) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    side_next  = 1'b0;
                    edge_next  = '0;
                    state_next = ST_EDGE0;
                end
            end
            ST_EDGE0: begin
                cmd.rd_op   = cpsat_pkg::OP_EDGE0;
                cmd.rd_poly = side_reg;
                cmd.rd_addr = edge_reg;
                state_next  = ST_EDGE1;
            end
            ST_EDGE1: begin
                cmd.rd_op   = cpsat_pkg::OP_EDGE1;
                cmd.rd_poly = side_reg;
                cmd.rd_addr = edge_last ? '0 : edge_reg + 1'b1;
                pj_next     = 1'b0;
                j_next      = '0;
                state_next  = ST_PROJ;
            end
            ST_PROJ: begin
                cmd.rd_op    = cpsat_pkg::OP_PROJ;
                cmd.rd_poly  = pj_reg;
                cmd.rd_addr  = j_reg;
                cmd.rd_first = (j_reg == '0);
                if (!j_last) begin
                    j_next = j_reg + 1'b1;
                end else if (!pj_reg) begin
                    pj_next = 1'b1;
                    j_next  = '0;
                end else begin
                    wait_next  = 2'd2;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // read, multiply and min/max stages still in flight
                wait_next = wait_reg - 1'b1;
                if (wait_reg == 2'd1) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.separated) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (!edge_last) begin
                    edge_next  = edge_reg + 1'b1;
                    state_next = ST_EDGE0;
                end else if (!side_reg) begin
                    side_next  = 1'b1;
                    edge_next  = '0;
                    state_next = ST_EDGE0;
                end else begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        side_reg <= side_next;
        edge_reg <= edge_next;
        pj_reg   <= pj_next;
        j_reg    <= j_next;
        wait_reg <= wait_next;
        res_reg  <= res_next;
        if (state_reg == ST_DONE && out_free) begin
            m_collide_reg  <= res_reg;
            m_overflow_reg <= stat.dropped;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_collide  = m_collide_reg;
    assign m_overflow = m_overflow_reg;

endmodule

// File: sv/convex_polygon_sat_overlap_core.sv
// Top level of the two-polygon separating-axis overlap core.
//
// Usage:
//   Input channel (s_*): one vertex per request, tagged by s_polygon_select
//   (0 first polygon, 1 second). s_last_item marks the final vertex of the
//   pair and starts the test. Each polygon holds up to 16 vertices; further
//   vertices of a full polygon are dropped and flagged as overflow.
//   Output channel (m_*): one request per pair, m_collide and m_overflow.
//   Loading: one vertex per cycle while the core is idle.
//   Test: first a check for empty polygons and bounding-box overlap; if
//   the boxes overlap, the axes are walked one by one through the single
//   shared dot-product unit (store read, multiply, min/max stages), for
//   up to n1 + n2 axes, stopping at the first separating axis.
//   Reset (synchronous, aresetn low) empties both polygons, clears the
//   overflow flag and drops any pending result.
//   The result sits in an output register; while the receiver stalls,
//   input is refused only once the next pair is complete and its result
//   cannot yet be placed.
`timescale 1ns / 1ps

module convex_polygon_sat_overlap_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_polygon_select,
    input  logic signed [15:0]       s_vertex_x,
    input  logic signed [15:0]       s_vertex_y,
    input  logic                     s_last_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_collide,
    output logic                     m_overflow
);

    cpsat_pkg::cmd_t  cmd;
    cpsat_pkg::stat_t stat;

    // sequencer: handshakes, axis walk, output register
    cpsat_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_polygon_select (s_polygon_select),
        .s_last_item      (s_last_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_collide        (m_collide),
        .m_overflow       (m_overflow),
        .cmd              (cmd),
        .stat             (stat)
    );

    // stores, boxes and projection pipeline; coordinates are the low
    // COORD_BITS bits of each field
    cpsat_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .load_x  (s_vertex_x[cpsat_pkg::COORD_BITS-1:0]),
        .load_y  (s_vertex_y[cpsat_pkg::COORD_BITS-1:0]),
        .stat    (stat)
    );

endmodule

// File: tb/tb_convex_polygon_sat_overlap_core.sv
// Self-checking testbench for the two-polygon separating-axis overlap core.
`timescale 1ns / 1ps

module tb_convex_polygon_sat_overlap_core;

    typedef cpsat_pkg::coord_t coord_t;
    localparam int MAX_VERTICES = cpsat_pkg::MAX_VERTICES;

    // One vertex request as it goes onto the input channel
    typedef struct {
        bit     second;
        coord_t x;
        coord_t y;
        bit     last;
    } vertex_req_t;

    // One expected verdict per completed pair
    typedef struct {
        bit collide;
        bit overflow;
    } verdict_t;

    logic         aclk             = 1'b0;
    logic         aresetn          = 1'b0;
    logic         s_valid          = 1'b0;
    logic         s_ready;
    logic         s_polygon_select = 1'b0;
    coord_t       s_vertex_x       = '0;
    coord_t       s_vertex_y       = '0;
    logic         s_last_item      = 1'b0;
    logic         m_valid;
    logic         m_ready          = 1'b0;
    logic         m_collide;
    logic         m_overflow;

    vertex_req_t  vertex_q[$];      // requests still to be driven
    verdict_t     verdict_q[$];     // verdicts owed by the core, oldest first

    // Predictor state: both vertex stores, their fill counts, drop flag
    coord_t       poly_x[2][MAX_VERTICES];
    coord_t       poly_y[2][MAX_VERTICES];
    int           poly_n[2];
    bit           lost_vertex;

    // Scratch shapes for the stimulus generator (up to a few beyond capacity)
    coord_t       shape_x[2][20];
    coord_t       shape_y[2][20];

    bit           in_taken;         // set at the edge a request is accepted
    int           taken_count;
    int           pair_count;
    int           collide_count;
    int           overflow_count;
    int           fail_count;
    int           send_idle;
    int           recv_idle;

    convex_polygon_sat_overlap_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_polygon_select (s_polygon_select),
        .s_vertex_x       (s_vertex_x),
        .s_vertex_y       (s_vertex_y),
        .s_last_item      (s_last_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_collide        (m_collide),
        .m_overflow       (m_overflow)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Min and max of the dot products of polygon p with the axis (ax, ay).
    // Coordinates are 16 bit and axes 17 bit, so 64-bit sums are exact.
    function automatic void project_onto(input int p, input longint ax, input longint ay,
                                         output longint lo, output longint hi);
        longint d;
        lo = longint'(poly_x[p][0]) * ax + longint'(poly_y[p][0]) * ay;
        hi = lo;
        for (int i = 1; i < poly_n[p]; i++) begin
            d = longint'(poly_x[p][i]) * ax + longint'(poly_y[p][i]) * ay;
            if (d < lo) lo = d;
            if (d > hi) hi = d;
        end
    endfunction

    // True if some edge normal of polygon a leaves a gap between a and b.
    // Touching intervals do not count as a gap; a zero-length edge gives a
    // null axis on which everything projects to 0.
    function automatic bit edge_separates(input int a, input int b);
        longint ax, ay, alo, ahi, blo, bhi;
        int     j;
        for (int i = 0; i < poly_n[a]; i++) begin
            j  = (i + 1 >= poly_n[a]) ? 0 : i + 1;
            ax = longint'(poly_y[a][i]) - longint'(poly_y[a][j]);
            ay = longint'(poly_x[a][j]) - longint'(poly_x[a][i]);
            project_onto(a, ax, ay, alo, ahi);
            project_onto(b, ax, ay, blo, bhi);
            if (alo > bhi || ahi < blo)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Full verdict on the stored pair: empty check, strict box overlap,
    // then the axis sweep over both polygons' edges.
    function automatic bit polygons_touch();
        int lo_x[2], hi_x[2], lo_y[2], hi_y[2];
        if (poly_n[0] == 0 || poly_n[1] == 0)
            return 1'b0;
        for (int p = 0; p < 2; p++) begin
            lo_x[p] = poly_x[p][0];
            hi_x[p] = poly_x[p][0];
            lo_y[p] = poly_y[p][0];
            hi_y[p] = poly_y[p][0];
            for (int i = 1; i < poly_n[p]; i++) begin
                if (poly_x[p][i] < lo_x[p]) lo_x[p] = poly_x[p][i];
                if (poly_x[p][i] > hi_x[p]) hi_x[p] = poly_x[p][i];
                if (poly_y[p][i] < lo_y[p]) lo_y[p] = poly_y[p][i];
                if (poly_y[p][i] > hi_y[p]) hi_y[p] = poly_y[p][i];
            end
        end
        // boxes that merely share an edge are a miss
        if (!(lo_x[0] < hi_x[1] && hi_x[0] > lo_x[1] &&
              lo_y[0] < hi_y[1] && hi_y[0] > lo_y[1]))
            return 1'b0;
        return !edge_separates(0, 1) && !edge_separates(1, 0);
    endfunction

    // Store one accepted vertex; on the closing vertex queue the verdict
    // and start a fresh pair. A vertex for a full store is dropped, the
    // closing vertex included.
    task automatic absorb_vertex(input vertex_req_t v);
        verdict_t   want;
        int         p;
        p = v.second;
        if (poly_n[p] < MAX_VERTICES) begin
            poly_x[p][poly_n[p]] = v.x;
            poly_y[p][poly_n[p]] = v.y;
            poly_n[p]++;
        end else begin
            lost_vertex = 1'b1;
        end
        if (v.last) begin
            want.collide  = polygons_touch();
            want.overflow = lost_vertex;
            verdict_q.push_back(want);
            poly_n[0]   = 0;
            poly_n[1]   = 0;
            lost_vertex = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic send_vertex(input bit sec, input int x, input int y, input bit last);
        vertex_req_t v;
        v.second = sec;
        v.x      = coord_t'(x);
        v.y      = coord_t'(y);
        v.last   = last;
        vertex_q.push_back(v);
    endtask

    function automatic coord_t clamp16(input int v);
        if (v > 32767)  return coord_t'(32767);
        if (v < -32768) return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    // Mostly small polygons; now and then empty, tiny, or past capacity
    function automatic int vertex_count_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 0;
        if (r < 12) return $urandom_range(15, 19);
        if (r < 20) return $urandom_range(1, 2);
        return $urandom_range(3, 8);
    endfunction

    // Vertices roughly on a circle, in angular order so the shape is convex
    // until the clamp to the coordinate range bends it. Scatter mode fills
    // in raw random coordinates instead.
    task automatic make_shape(input int p, input int cnt, input int cx, input int cy,
                              input int rad, input bit scatter);
        real step, phase, ang;
        step  = 6.283185307 / ((cnt > 0) ? cnt : 1);
        phase = $urandom_range(0, 999) * step / 1000.0;
        for (int i = 0; i < cnt; i++) begin
            ang = phase + i * step;
            if (scatter) begin
                shape_x[p][i] = coord_t'($urandom);
                shape_y[p][i] = coord_t'($urandom);
            end else begin
                shape_x[p][i] = clamp16(cx + int'(rad * $cos(ang)));
                shape_y[p][i] = clamp16(cy + int'(rad * $sin(ang)));
            end
        end
    endtask

    // Queue a pair, optionally interleaving the two polygons' vertices;
    // whichever vertex comes out last closes the pair.
    task automatic emit_pair(input int n0, input int n1, input bit interleave);
        int k0, k1, p;
        k0 = 0;
        k1 = 0;
        while (k0 < n0 || k1 < n1) begin
            if (k0 >= n0)
                p = 1;
            else if (k1 >= n1)
                p = 0;
            else
                p = interleave ? $urandom_range(0, 1) : 0;
            if (p == 0) begin
                k0++;
                send_vertex(0, shape_x[0][k0-1], shape_y[0][k0-1], k0 == n0 && k1 == n1);
            end else begin
                k1++;
                send_vertex(1, shape_x[1][k1-1], shape_y[1][k1-1], k0 == n0 && k1 == n1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: requests and receiver back-pressure change at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        vertex_req_t v;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            // idling profile: receiver lazy first, then sender, then neither
            if (taken_count < 160) begin
                send_idle = 28;
                recv_idle = 68;
            end else if (taken_count < 320) begin
                send_idle = 68;
                recv_idle = 28;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
            // a request stays put until taken; only then may the next go up
            if (!s_valid || in_taken) begin
                if (vertex_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    v = vertex_q.pop_front();
                    s_valid          <= 1'b1;
                    s_polygon_select <= v.second;
                    s_vertex_x       <= v.x;
                    s_vertex_y       <= v.y;
                    s_last_item      <= v.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. Results are
    // checked before the new request is absorbed, so a verdict can never
    // be matched against its own closing vertex in the same edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t    want;
        vertex_req_t v;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                pair_count++;
                if (m_collide === 1'b1)  collide_count++;
                if (m_overflow === 1'b1) overflow_count++;
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no pair pending", pair_count));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_collide !== want.collide)
                        report_mismatch($sformatf("result %0d collide: got %b, expected %b",
                                                  pair_count, m_collide, want.collide));
                    if (m_overflow !== want.overflow)
                        report_mismatch($sformatf("result %0d overflow: got %b, expected %b",
                                                  pair_count, m_overflow, want.overflow));
                end
            end
            if (s_valid && s_ready) begin
                v.second = s_polygon_select;
                v.x      = s_vertex_x;
                v.y      = s_vertex_y;
                v.last   = s_last_item;
                absorb_vertex(v);
                in_taken = 1'b1;
                taken_count++;
            end
        end
    end

    // Hard stop well beyond the slowest legal run (every pair at its worst
    // case, plus stalls)
    initial begin
        #12_000_000;
        $display("** convex_polygon_sat_overlap_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int n0, n1, rad0, rad1, cx0, cy0, cx1, cy1, reach;
        bit scatter;

        poly_n[0]      = 0;
        poly_n[1]      = 0;
        lost_vertex    = 1'b0;
        in_taken       = 1'b0;
        taken_count    = 0;
        pair_count     = 0;
        collide_count  = 0;
        overflow_count = 0;
        fail_count     = 0;

        // first polygon empty: a lone second-polygon vertex closes the pair
        send_vertex(1, 0, 0, 1);
        // full-range square around a small triangle: overlap
        send_vertex(0, -32768, -32768, 0);
        send_vertex(0,  32767, -32768, 0);
        send_vertex(0,  32767,  32767, 0);
        send_vertex(0, -32768,  32767, 0);
        send_vertex(1, 0, 0, 0);
        send_vertex(1, 16, 0, 0);
        send_vertex(1, 0, 16, 1);
        // boxes sharing only an edge: miss
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 16, 0, 0);
        send_vertex(0, 16, 16, 0);
        send_vertex(1, 16, 0, 0);
        send_vertex(1, 32, 0, 0);
        send_vertex(1, 32, 16, 1);
        // boxes overlap but the hypotenuse separates; interleaved, with
        // a repeated vertex in the second triangle
        send_vertex(0, 0, 0, 0);
        send_vertex(1, 48, 48, 0);
        send_vertex(0, 64, 0, 0);
        send_vertex(1, 64, 48, 0);
        send_vertex(1, 64, 48, 0);
        send_vertex(0, 0, 64, 0);
        send_vertex(1, 48, 64, 1);
        // segment against a single point on it: touching projections
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 32, 32, 0);
        send_vertex(1, 16, 16, 1);

        // random pairs: mostly circle-ish convex shapes placed close enough
        // to both hit and miss, some raw-noise pairs and overfull stores
        while (vertex_q.size() < 430) begin
            n0 = vertex_count_pick();
            n1 = vertex_count_pick();
            if (n0 + n1 == 0)
                n0 = 3;
            scatter = ($urandom_range(0, 99) < 10);
            rad0 = ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 40000)
                                               : $urandom_range(1, 1500);
            rad1 = ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 40000)
                                               : $urandom_range(1, 1500);
            cx0   = int'($urandom_range(0, 65535)) - 32768;
            cy0   = int'($urandom_range(0, 65535)) - 32768;
            reach = rad0 + rad1;
            cx1   = cx0 + int'($urandom_range(0, 2 * reach)) - reach;
            cy1   = cy0 + int'($urandom_range(0, 2 * reach)) - reach;
            make_shape(0, n0, cx0, cy0, rad0, scatter);
            make_shape(1, n1, cx1, cy1, rad1, scatter);
            emit_pair(n0, n1, $urandom_range(0, 1));
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all requests in, all verdicts out
        while (vertex_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge aclk);
        // long enough for a full-size axis sweep, to catch stray results
        repeat (1300) @(posedge aclk);

        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

        $display("Drove %0d vertex requests forming %0d pairs: %0d collisions, %0d overflows.",
                 taken_count, pair_count, collide_count, overflow_count);
        $display("Stalls on either side, then none; %0d mismatches seen.", fail_count);
        if (fail_count == 0)
            $display("** convex_polygon_sat_overlap_core: PASSED **");
        else
            $display("** convex_polygon_sat_overlap_core: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
sv/cpsat_pkg.sv
sv/cpsat_datapath.sv
sv/cpsat_ctrl.sv
sv/convex_polygon_sat_overlap_core.sv
tb/tb_convex_polygon_sat_overlap_core.sv
